// File: rtl/core/cartridge_bank_mapper_with_irq_defines.svh
// assertion helpers for the mapper rtl
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_DEFINES_SVH

// same-cycle implication, off during reset
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cbm_pkg.sv
package cbm_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE,
    FUNC_READ,
    FUNC_TRANSLATE,
    FUNC_TICK
  } func_t;

  typedef enum logic [2:0] {
    KIND_PRG_ROM,
    KIND_CHR_ROM,
    KIND_CHR_RAM,
    KIND_NT_RAM,
    KIND_BOARD_DEFAULT,
    KIND_UNMAPPED
  } kind_t;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NT_ENABLE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_BANK = 4'd1;

  // cpu address bits 15..11
  localparam logic [4:0] SEL_IRQ_LO = 5'h0A;
  localparam logic [4:0] SEL_IRQ_HI = 5'h0B;
  localparam logic [4:0] SEL_PRG0   = 5'h1C;
  localparam logic [4:0] SEL_PRG1   = 5'h1D;
  localparam logic [4:0] SEL_PRG2   = 5'h1E;

  localparam logic [2:0]  RAM_PAGE_TOP = 3'b111;  // value >= 0xE0
  localparam logic [14:0] COUNT_MAX    = 15'h7FFF;

  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    kind_t      target_kind;
    logic [7:0] bank_number;
  } result_t;

  typedef struct packed {
    logic       nt_enable;
    logic [5:0] last_bank;
  } cfg_t;

endpackage

// File: rtl/core/cbm_mapper.sv
module cbm_mapper import cbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [8:0]  pattern_banks [8];
  logic [7:0]  nt_sel [4];
  logic [5:0]  prg_banks [3];
  logic        dis_low;
  logic        dis_high;
  logic [14:0] count;
  logic        irq_en;
  logic        pending;

  logic [8:0]  pattern_next;
  logic        pattern_we;
  logic [7:0]  nt_next;
  logic        nt_we;
  logic [5:0]  prg_next;
  logic [2:0]  prg_we;
  logic        dis_low_next;
  logic        dis_high_next;
  logic [14:0] count_next;
  logic        irq_en_next;
  logic        pending_next;

  always_comb begin
    logic [4:0]  sel;
    logic        dis;
    logic [13:0] pa;
    logic [8:0]  pat;
    logic [7:0]  s;
    sel = item.address[15:11];
    pa  = item.address[13:0];
    dis = item.address[13] ? dis_high : dis_low;
    pat = pattern_banks[pa[12:10]];
    s   = nt_sel[pa[11:10]];

    pattern_next  = {1'b0, item.data};
    pattern_we    = 1'b0;
    nt_next       = item.data;
    nt_we         = 1'b0;
    prg_next      = item.data[5:0];
    prg_we        = 3'b000;
    dis_low_next  = dis_low;
    dis_high_next = dis_high;
    count_next    = count;
    irq_en_next   = irq_en;
    pending_next  = pending;

    res.read_data   = 8'd0;
    res.target_kind = KIND_UNMAPPED;
    res.bank_number = 8'd0;

    case (item.func)
      FUNC_WRITE: begin
        if (sel == SEL_IRQ_LO) begin
          pending_next = 1'b0;
          count_next   = {count[14:8], item.data};
        end else if (sel == SEL_IRQ_HI) begin
          pending_next = 1'b0;
          count_next   = {item.data[6:0], count[7:0]};
          irq_en_next  = item.data[7];
        end else if (item.address[15:14] == 2'b10) begin
          pattern_we = 1'b1;
          // ram page chosen at write time, offset from 0xe0
          if (!dis && item.data[7:5] == RAM_PAGE_TOP) begin
            pattern_next = {1'b1, 3'b000, item.data[4:0]};
          end
        end else if (item.address[15:13] == 3'b110) begin
          nt_we = cfg.nt_enable;
        end else if (sel == SEL_PRG0) begin
          prg_we = 3'b001;
        end else if (sel == SEL_PRG1) begin
          prg_we        = 3'b010;
          dis_low_next  = item.data[6];
          dis_high_next = item.data[7];
        end else if (sel == SEL_PRG2) begin
          prg_we = 3'b100;
        end
      end
      FUNC_READ: begin
        if (sel == SEL_IRQ_LO) begin
          pending_next  = 1'b0;
          res.read_data = count[7:0];
        end else if (sel == SEL_IRQ_HI) begin
          pending_next  = 1'b0;
          res.read_data = {irq_en, count[14:8]};
        end else if (item.address[15]) begin
          res.target_kind = KIND_PRG_ROM;
          case (item.address[14:13])
            2'd0:    res.bank_number = {2'b00, prg_banks[0]};
            2'd1:    res.bank_number = {2'b00, prg_banks[1]};
            2'd2:    res.bank_number = {2'b00, prg_banks[2]};
            default: res.bank_number = {2'b00, cfg.last_bank};
          endcase
        end
      end
      FUNC_TRANSLATE: begin
        if (!pa[13]) begin
          res.target_kind = pat[8] ? KIND_CHR_RAM : KIND_CHR_ROM;
          res.bank_number = pat[7:0];
        end else if (cfg.nt_enable) begin
          if (s[7:5] == RAM_PAGE_TOP) begin
            res.target_kind = KIND_NT_RAM;
            res.bank_number = {7'd0, s[0]};
          end else begin
            res.target_kind = KIND_CHR_ROM;
            res.bank_number = s;
          end
        end else begin
          res.target_kind = KIND_BOARD_DEFAULT;
        end
      end
      default: begin
        if (irq_en) begin
          if (count == COUNT_MAX) begin
            pending_next = 1'b1;
            count_next   = 15'd0;
          end else begin
            count_next = count + 15'd1;
          end
        end
      end
    endcase

    res.irq_line = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) pattern_banks[i] <= 9'd0;
      for (int i = 0; i < 4; i++) nt_sel[i] <= 8'd0;
      for (int i = 0; i < 3; i++) prg_banks[i] <= 6'd0;
      dis_low  <= 1'b0;
      dis_high <= 1'b0;
      count    <= 15'd0;
      irq_en   <= 1'b0;
      pending  <= 1'b0;
    end else if (step) begin
      if (pattern_we) pattern_banks[item.address[13:11]] <= pattern_next;
      if (nt_we) nt_sel[item.address[12:11]] <= nt_next;
      for (int i = 0; i < 3; i++) begin
        if (prg_we[i]) prg_banks[i] <= prg_next;
      end
      dis_low  <= dis_low_next;
      dis_high <= dis_high_next;
      count    <= count_next;
      irq_en   <= irq_en_next;
      pending  <= pending_next;
    end
  end

endmodule

// File: rtl/core/cartridge_bank_mapper_with_irq.sv
// pipeline: an accepted item is registered in the first stage, then in the result register,
// from which its result transfers out; one item per cycle sustained, limited only by
// result_stall through the result register
// reset: synchronous, active high; clears the valid flags of both stages, all bank,
// selector and irq state to zero, selectors enabled and last program bank 63
`include "cartridge_bank_mapper_with_irq_defines.svh"

module cartridge_bank_mapper_with_irq import cbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_go;
  logic    s1_ctr_read;
  cfg_t    cfg;
  result_t res;

  assign s1_go      = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_go;
  assign cfg_ready  = 1'b1;

  // counter area read leaving the first stage
  assign s1_ctr_read = s1_go && s1_item.func == FUNC_READ && s1_item.address[15:12] == 4'h5;

  cbm_mapper u_mapper (
    .clk  (clk),
    .rst  (rst),
    .step (s1_go),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      cfg.nt_enable <= 1'b1;
      cfg.last_bank <= 6'd63;
    end else begin
      if (!item_stall) s1_valid <= item_valid;
      if (s1_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NT_ENABLE: cfg.nt_enable <= cfg_data[0];
          CFG_LAST_BANK: cfg.last_bank <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) s1_item <= item;
    if (s1_go) result <= res;
  end

  `CBM_ASSERT_NOW(a_stall_needs_item, item_stall, s1_valid && result_valid, "stall with empty stage")
  `CBM_ASSERT_NEXT(a_transfer_fills_stage, item_valid && !item_stall, s1_valid, "transfer lost")
  `CBM_ASSERT_NEXT(a_ctr_read_clears_irq, s1_ctr_read, result_valid && !result.irq_line, "irq kept")

endmodule
